// ===== hdl/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg
// Shared widths, codes, types and helper functions of the coverage tracker.
// ----------------------------------------------------------------------------
package ftc_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int PC_W            = 64;
  localparam int CMD_W           = 2;
  localparam int SIZE_W          = 13;
  localparam int WEIGHT_W        = 16;
  localparam int CNT_W           = 32;
  localparam int HIT_W           = 17;
  localparam int BUCKET_COUNT    = 32;
  localparam int BUCKET_W        = BUCKET_COUNT - 1;
  localparam int EDGE_SHIFT      = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TRACE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PC_WEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_WEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_WEIGHT   = 3'd4;

  localparam logic [SIZE_W-1:0]   TABLE_SIZE_RST   = 13'd4096;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST       = 16'd1;
  localparam logic [PC_W-1:0]     BACK_JUMP_OFFSET = 64'd16807;
  localparam logic [HIT_W-1:0]    HIT_MAX          = 17'd65536;

  localparam logic [HIT_W-1:0] BUCKET_LIMIT [BUCKET_COUNT] = '{
    17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9,
    17'd10, 17'd11, 17'd12, 17'd13, 17'd14, 17'd15, 17'd16, 17'd32,
    17'd33, 17'd63, 17'd64, 17'd65, 17'd255, 17'd256, 17'd257, 17'd1023,
    17'd1024, 17'd1025, 17'd32767, 17'd32768, 17'd32769, 17'd65534, 17'd65535,
    17'd65536
  };

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [PC_W-1:0]  pc;
  } ftc_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   table_size;
    logic [WEIGHT_W-1:0] pc_weight;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [WEIGHT_W-1:0] bucket_weight;
    logic [WEIGHT_W-1:0] path_weight;
  } ftc_cfg_t;

  // Back end to front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } ftc_ctl_t;

  // Bucket bit for a hit count: bit j-1 where limit[j-1] <= c < limit[j]
  function automatic logic [BUCKET_W-1:0] bucket_mask(input logic [HIT_W-1:0] c);
    logic [BUCKET_W-1:0] m;
    m = '0;
    for (int j = 1; j < BUCKET_COUNT; j++) begin
      m[j-1] = (c >= BUCKET_LIMIT[j-1]) && (c < BUCKET_LIMIT[j]);
    end
    return m;
  endfunction

  // Saturating weight add
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] w);
    logic [CNT_W:0] s;
    s = {1'b0, a} + (CNT_W+1)'(w);
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== hdl/ftc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// ftc_cmd_if
// Command channel: valid/ready with command code and program counter.
// ----------------------------------------------------------------------------
interface ftc_cmd_if;
  import ftc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [PC_W-1:0]  pc;

  modport source (output valid, output command, output pc, input ready);
  modport sink   (input valid, input command, input pc, output ready);
endinterface

// ===== hdl/ftc_res_if.sv =====
// ----------------------------------------------------------------------------
// ftc_res_if
// Result channel: valid/ready with flag, weight, path hash and totals.
// ----------------------------------------------------------------------------
interface ftc_res_if;
  import ftc_pkg::*;

  logic             valid;
  logic             ready;
  logic             new_feature;
  logic [CNT_W-1:0] weight_sum;
  logic [PC_W-1:0]  last_path_hash;
  logic [CNT_W-1:0] pc_total;
  logic [CNT_W-1:0] edge_total;
  logic [CNT_W-1:0] bucket_total;
  logic [CNT_W-1:0] path_total;

  modport source (output valid, output new_feature, output weight_sum,
                  output last_path_hash, output pc_total, output edge_total,
                  output bucket_total, output path_total, input ready);
  modport sink   (input valid, input new_feature, input weight_sum,
                  input last_path_hash, input pc_total, input edge_total,
                  input bucket_total, input path_total, output ready);
endinterface

// ===== hdl/fuzz_coverage_tracker_core.sv =====
// ----------------------------------------------------------------------------
// fuzz_coverage_tracker_core
// Coverage tracker: PC, edge, hit-count bucket and path novelty with weights.
// ----------------------------------------------------------------------------
// Work per command: a trace runs two remainders of a 64-bit value, four bits
//   per cycle, plus table read-modify-writes; an end of run runs one remainder
//   and a bucket read-modify-write per touched index; clear, unused commands
//   and an empty end of run go straight to the result.
// Throughput: one command at a time in the back end; a two-entry queue
//   keeps taking beats while it works or while a result waits.
// Reset: a clearing pass zeroes the tables; no beat is taken during it,
//   configuration writes are.
module fuzz_coverage_tracker_core #(
  parameter int TABLE_DEPTH = ftc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  ftc_cmd_if.sink                        cmd_ch,
  ftc_res_if.source                      res_ch,
  input  logic                           cfg_we,
  input  logic [ftc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ftc_pkg::*;

  ftc_cfg_t  cfg;
  ftc_ctl_t  ctl;
  logic      q_valid;
  ftc_item_t q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.table_size    <= TABLE_SIZE_RST;
      cfg.pc_weight     <= WEIGHT_RST;
      cfg.edge_weight   <= WEIGHT_RST;
      cfg.bucket_weight <= WEIGHT_RST;
      cfg.path_weight   <= WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_SIZE:    cfg.table_size    <= cfg_data[SIZE_W-1:0];
        REG_PC_WEIGHT:     cfg.pc_weight     <= cfg_data[WEIGHT_W-1:0];
        REG_EDGE_WEIGHT:   cfg.edge_weight   <= cfg_data[WEIGHT_W-1:0];
        REG_BUCKET_WEIGHT: cfg.bucket_weight <= cfg_data[WEIGHT_W-1:0];
        REG_PATH_WEIGHT:   cfg.path_weight   <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  ftc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .ctl     (ctl),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  ftc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item),
    .ctl     (ctl),
    .res     (res_ch)
  );

endmodule

// ===== hdl/ftc_front.sv =====
// ----------------------------------------------------------------------------
// ftc_front
// Accepts command beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ftc_front (
  input  logic              clk,
  input  logic              rst,
  ftc_cmd_if.sink           cmd,
  input  ftc_pkg::ftc_ctl_t ctl,
  output logic              q_valid,
  output ftc_pkg::ftc_item_t q_item
);
  import ftc_pkg::*;

  localparam int QUEUE_DEPTH = 2;

  ftc_item_t  slot [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  // Take a beat while there is room and no table clearing runs
  assign cmd.ready = (fill != 2'(QUEUE_DEPTH)) && !ctl.clearing;
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slot[rd_ptr];

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{command: cmd.command, pc: cmd.pc};
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (ctl.pop) rd_ptr <= ~rd_ptr;
      if (push && !ctl.pop) fill <= fill + 2'd1;
      else if (!push && ctl.pop) fill <= fill - 2'd1;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> fill != 2'd0) else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_no_push_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clearing |-> !push) else $error("beat taken during clearing");

endmodule

// ===== hdl/ftc_mod.sv =====
// ----------------------------------------------------------------------------
// ftc_mod
// Remainder of a 64-bit value by the table size, four bits per cycle.
// ----------------------------------------------------------------------------
module ftc_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ftc_pkg::PC_W-1:0]   dividend,
  input  logic [ftc_pkg::SIZE_W-1:0] modulus,
  output logic                       done,
  output logic [ftc_pkg::SIZE_W-1:0] rem
);
  import ftc_pkg::*;

  localparam int STEP_BITS = 4;
  localparam int STEPS     = PC_W / STEP_BITS;
  localparam int STEP_CW   = $clog2(STEPS);

  logic               busy;
  logic [STEP_CW-1:0] cnt;
  logic [PC_W-1:0]    shreg;
  logic [SIZE_W-1:0]  m_reg;
  logic [SIZE_W-1:0]  rem_next;
  logic [SIZE_W:0]    part;

  // Four restoring steps: remainder stays below the modulus
  always_comb begin
    rem_next = rem;
    part     = '0;
    for (int k = 0; k < STEP_BITS; k++) begin
      part = {rem_next, shreg[PC_W-1-k]};
      if (part >= {1'b0, m_reg}) part = part - {1'b0, m_reg};
      rem_next = part[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend in, most significant bits first
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      m_reg <= modulus;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << STEP_BITS;
      rem   <= rem_next;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("remainder unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without a running division");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < m_reg) else $error("remainder not below modulus");

endmodule

// ===== hdl/ftc_back.sv =====
// ----------------------------------------------------------------------------
// ftc_back
// Executes queued commands against the coverage tables and drives results.
// ----------------------------------------------------------------------------
module ftc_back #(
  parameter int TABLE_DEPTH = ftc_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ftc_pkg::ftc_cfg_t  cfg,
  input  logic               q_valid,
  input  ftc_pkg::ftc_item_t q_item,
  output ftc_pkg::ftc_ctl_t  ctl,
  ftc_res_if.source          res
);
  import ftc_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int TC_W  = IDX_W + 1;
  localparam int CMP_W = IDX_W + SIZE_W + 1;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_FORM    = 5'd1;
  localparam logic [4:0] ST_PCMOD   = 5'd2;
  localparam logic [4:0] ST_PCRD    = 5'd3;
  localparam logic [4:0] ST_PCUPD   = 5'd4;
  localparam logic [4:0] ST_EDMOD   = 5'd5;
  localparam logic [4:0] ST_EDRD    = 5'd6;
  localparam logic [4:0] ST_EDUPD   = 5'd7;
  localparam logic [4:0] ST_PATHMOD = 5'd8;
  localparam logic [4:0] ST_PATHRD  = 5'd9;
  localparam logic [4:0] ST_PATHUPD = 5'd10;
  localparam logic [4:0] ST_LISTRD  = 5'd11;
  localparam logic [4:0] ST_LISTWT  = 5'd12;
  localparam logic [4:0] ST_BKRD    = 5'd13;
  localparam logic [4:0] ST_BKUPD   = 5'd14;
  localparam logic [4:0] ST_RUNEND  = 5'd15;
  localparam logic [4:0] ST_DONE    = 5'd16;

  // Coverage tables and touched list
  logic                pc_seen     [TABLE_DEPTH];
  logic                edge_seen   [TABLE_DEPTH];
  logic                path_seen   [TABLE_DEPTH];
  logic [HIT_W-1:0]    hit_count   [TABLE_DEPTH];
  logic [BUCKET_W-1:0] bucket_bits [TABLE_DEPTH];
  logic [IDX_W-1:0]    touched_list[TABLE_DEPTH];

  logic [4:0]          state;
  ftc_item_t           cur;
  logic [PC_W-1:0]     edge_val;
  logic [IDX_W-1:0]    addr;
  logic [IDX_W-1:0]    clr_addr;
  logic                clearing;
  logic [IDX_W-1:0]    tbl_addr;
  logic [TC_W-1:0]     touched_count;
  logic [TC_W-1:0]     walk;
  logic [PC_W-1:0]     run_hash;
  logic [PC_W-1:0]     previous_pc;
  logic [PC_W-1:0]     captured_hash;
  logic                feature_flag;
  logic [CNT_W-1:0]    weight_acc;
  logic [CNT_W-1:0]    pc_total;
  logic [CNT_W-1:0]    edge_total;
  logic [CNT_W-1:0]    bucket_total;
  logic [CNT_W-1:0]    path_total;

  logic                pcs_rd, eds_rd, pts_rd;
  logic [HIT_W-1:0]    hit_rd;
  logic [BUCKET_W-1:0] bk_rd;
  logic [IDX_W-1:0]    list_rd;

  logic                pcs_we, eds_we, pts_we, hit_we, bk_we, list_we;
  logic                seen_wd;
  logic [HIT_W-1:0]    hit_wd;
  logic [BUCKET_W-1:0] bk_wd;

  logic                res_valid;
  logic [SIZE_W-1:0]   m_eff;
  logic [PC_W-1:0]     edge_next;
  logic [HIT_W-1:0]    hit_inc;
  logic                first_hit;
  logic                list_room;
  logic [BUCKET_W-1:0] bk_mask;
  logic                bk_new;
  logic                nov;
  logic [WEIGHT_W-1:0] nov_w;
  logic                mod_start;
  logic [PC_W-1:0]     mod_div;
  logic                mod_done;
  logic [SIZE_W-1:0]   mod_rem;

  // Effective modulus: zero acts as one, above depth acts as depth
  always_comb begin
    if (cfg.table_size == '0) m_eff = SIZE_W'(1);
    else if (CMP_W'(cfg.table_size) > CMP_W'(TABLE_DEPTH)) m_eff = SIZE_W'(TABLE_DEPTH);
    else m_eff = cfg.table_size;
  end

  // Edge value from previous and current pc
  assign edge_next = (previous_pc ^ (cur.pc << EDGE_SHIFT)) +
                     ((cur.pc < previous_pc) ? BACK_JUMP_OFFSET : '0);

  assign hit_inc   = (hit_rd < HIT_MAX) ? hit_rd + 1'b1 : hit_rd;
  assign first_hit = (hit_inc == HIT_W'(1));
  assign list_room = (touched_count < TC_W'(TABLE_DEPTH));
  assign bk_mask   = bucket_mask(hit_rd);
  assign bk_new    = ((bk_mask & ~bk_rd) != '0);

  assign ctl.pop      = (state == ST_IDLE) && !clearing && q_valid;
  assign ctl.clearing = clearing;
  assign tbl_addr     = clearing ? clr_addr : addr;

  // Start the remainder unit for pc, edge value or run hash
  always_comb begin
    mod_start = 1'b0;
    mod_div   = cur.pc;
    if (state == ST_FORM) begin
      mod_start = 1'b1;
    end else if (state == ST_PCUPD) begin
      mod_start = 1'b1;
      mod_div   = edge_val;
    end else if (ctl.pop && q_item.command == CMD_END && touched_count != '0) begin
      mod_start = 1'b1;
      mod_div   = run_hash;
    end
  end

  ftc_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_div),
    .modulus  (m_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Table write controls and novelty selection
  always_comb begin
    pcs_we  = 1'b0;
    eds_we  = 1'b0;
    pts_we  = 1'b0;
    hit_we  = 1'b0;
    bk_we   = 1'b0;
    list_we = 1'b0;
    seen_wd = 1'b1;
    hit_wd  = hit_inc;
    bk_wd   = bk_rd | bk_mask;
    nov     = 1'b0;
    nov_w   = cfg.pc_weight;
    case (state)
      ST_PCUPD: begin
        pcs_we  = !pcs_rd;
        hit_we  = 1'b1;
        list_we = first_hit && list_room;
        nov     = !pcs_rd;
      end
      ST_EDUPD: begin
        eds_we = !eds_rd;
        nov    = !eds_rd;
        nov_w  = cfg.edge_weight;
      end
      ST_PATHUPD: begin
        pts_we = !pts_rd;
        nov    = !pts_rd;
        nov_w  = cfg.path_weight;
      end
      ST_BKUPD: begin
        bk_we  = 1'b1;
        hit_we = 1'b1;
        hit_wd = '0;
        nov    = bk_new;
        nov_w  = cfg.bucket_weight;
      end
      default: begin
        nov = 1'b0;
      end
    endcase
    // Clearing pass zeroes every table entry
    if (clearing) begin
      pcs_we  = 1'b1;
      eds_we  = 1'b1;
      pts_we  = 1'b1;
      hit_we  = 1'b1;
      bk_we   = 1'b1;
      seen_wd = 1'b0;
      hit_wd  = '0;
      bk_wd   = '0;
    end
  end

  // Table memories with registered read
  always_ff @(posedge clk) begin
    pcs_rd <= pc_seen[tbl_addr];
    eds_rd <= edge_seen[tbl_addr];
    pts_rd <= path_seen[tbl_addr];
    hit_rd <= hit_count[tbl_addr];
    bk_rd  <= bucket_bits[tbl_addr];
    if (pcs_we) pc_seen[tbl_addr]     <= seen_wd;
    if (eds_we) edge_seen[tbl_addr]   <= seen_wd;
    if (pts_we) path_seen[tbl_addr]   <= seen_wd;
    if (hit_we) hit_count[tbl_addr]   <= hit_wd;
    if (bk_we)  bucket_bits[tbl_addr] <= bk_wd;
  end

  always_ff @(posedge clk) begin
    list_rd <= touched_list[walk[IDX_W-1:0]];
    if (list_we) touched_list[touched_count[IDX_W-1:0]] <= addr;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!res_valid || res.ready)) begin
      res.new_feature    <= feature_flag;
      res.weight_sum     <= weight_acc;
      res.last_path_hash <= captured_hash;
      res.pc_total       <= pc_total;
      res.edge_total     <= edge_total;
      res.bucket_total   <= bucket_total;
      res.path_total     <= path_total;
    end
  end
  assign res.valid = res_valid;

  // Sequencer and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      clearing      <= 1'b1;
      clr_addr      <= '0;
      touched_count <= '0;
      walk          <= '0;
      run_hash      <= '0;
      previous_pc   <= '0;
      captured_hash <= '0;
      feature_flag  <= 1'b0;
      weight_acc    <= '0;
      pc_total      <= '0;
      edge_total    <= '0;
      bucket_total  <= '0;
      path_total    <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) clearing <= 1'b0;
      end

      // Load a new result beat or drop the one just taken
      if (state == ST_DONE && (!res_valid || res.ready)) res_valid <= 1'b1;
      else if (res_valid && res.ready) res_valid <= 1'b0;

      // Add novelty weight
      if (nov && nov_w != '0) begin
        feature_flag <= 1'b1;
        weight_acc   <= sat_add(weight_acc, nov_w);
      end

      case (state)
        ST_IDLE: begin
          if (ctl.pop) begin
            cur <= q_item;
            case (q_item.command)
              CMD_TRACE: state <= ST_FORM;
              CMD_END:   state <= (touched_count == '0) ? ST_DONE : ST_PATHMOD;
              CMD_CLEAR: begin
                feature_flag <= 1'b0;
                weight_acc   <= '0;
                state        <= ST_DONE;
              end
              default:   state <= ST_DONE;
            endcase
          end
        end
        ST_FORM: begin
          edge_val    <= edge_next;
          previous_pc <= cur.pc;
          state       <= ST_PCMOD;
        end
        ST_PCMOD: begin
          if (mod_done) begin
            addr  <= IDX_W'(mod_rem);
            state <= ST_PCRD;
          end
        end
        ST_PCRD: state <= ST_PCUPD;
        ST_PCUPD: begin
          if (!pcs_rd) pc_total <= pc_total + 1'b1;
          if (first_hit) begin
            run_hash <= run_hash + cur.pc;
            if (list_room) touched_count <= touched_count + 1'b1;
          end
          state <= ST_EDMOD;
        end
        ST_EDMOD: begin
          if (mod_done) begin
            addr  <= IDX_W'(mod_rem);
            state <= ST_EDRD;
          end
        end
        ST_EDRD: state <= ST_EDUPD;
        ST_EDUPD: begin
          if (!eds_rd) edge_total <= edge_total + 1'b1;
          state <= ST_DONE;
        end
        ST_PATHMOD: begin
          if (mod_done) begin
            addr  <= IDX_W'(mod_rem);
            state <= ST_PATHRD;
          end
        end
        ST_PATHRD: state <= ST_PATHUPD;
        ST_PATHUPD: begin
          if (!pts_rd) path_total <= path_total + 1'b1;
          walk  <= '0;
          state <= ST_LISTRD;
        end
        ST_LISTRD: state <= ST_LISTWT;
        ST_LISTWT: begin
          addr  <= list_rd;
          state <= ST_BKRD;
        end
        ST_BKRD: state <= ST_BKUPD;
        ST_BKUPD: begin
          if (bk_new) bucket_total <= bucket_total + 1'b1;
          walk  <= walk + 1'b1;
          state <= (walk + 1'b1 == touched_count) ? ST_RUNEND : ST_LISTRD;
        end
        ST_RUNEND: begin
          captured_hash <= run_hash;
          touched_count <= '0;
          run_hash      <= '0;
          previous_pc   <= '0;
          state         <= ST_DONE;
        end
        ST_DONE: begin
          if (!res_valid || res.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_tc_bound: assert property (@(posedge clk) disable iff (rst)
    touched_count <= TC_W'(TABLE_DEPTH)) else $error("touched count past depth");
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_BKUPD |-> walk < touched_count) else $error("walk past touched list");
  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == ST_IDLE && !ctl.pop) else $error("work during clearing");
  a_mod_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_PCMOD || state == ST_EDMOD || state == ST_PATHMOD))
    else $error("remainder result outside a wait state");

endmodule
